// File: design/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder package
// Shared types and constants for the frame decoder with failsafe.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfd_pkg;

  // Frame store geometry.
  localparam int FRAME_BYTES = 18;
  localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

  // Field widths.
  localparam int STICK_W = 11;
  localparam int SW_W    = 2;
  localparam int WORD_W  = 16;
  localparam int TMO_W   = 8;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 2;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_TIMEOUT_RELOAD = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_NEUTRAL_VALUE  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_FEEDER_STEP    = 2'd2;

  // Configuration reset values.
  localparam logic [TMO_W-1:0]   RST_TIMEOUT_RELOAD = 8'd10;
  localparam logic [STICK_W-1:0] RST_NEUTRAL_VALUE  = 11'd1024;
  localparam logic [WORD_W-1:0]  RST_FEEDER_STEP    = 16'd49152;

  // Switch positions of interest.
  localparam logic [SW_W-1:0] SW_POS_MID  = 2'd2;
  localparam logic [SW_W-1:0] SW_POS_SAFE = 2'd3;

  // Kind of work handed from the front to the back.
  typedef enum logic {
    JOB_FRAME = 1'b0,
    JOB_TICK  = 1'b1
  } job_kind_t;

  // Configuration register set.
  typedef struct packed {
    logic [TMO_W-1:0]   timeout_reload;
    logic [STICK_W-1:0] neutral_value;
    logic [WORD_W-1:0]  feeder_step;
  } cfg_t;

  // Decoded frame or tick request from the front.
  typedef struct packed {
    job_kind_t          kind;
    logic [STICK_W-1:0] stick0;
    logic [STICK_W-1:0] stick1;
    logic [STICK_W-1:0] stick2;
    logic [STICK_W-1:0] stick3;
    logic [SW_W-1:0]    sw1;
    logic [SW_W-1:0]    sw2;
    logic [WORD_W-1:0]  mouse_x;
    logic [WORD_W-1:0]  mouse_y;
    logic [WORD_W-1:0]  mouse_z;
    logic [WORD_W-1:0]  buttons;
    logic [WORD_W-1:0]  keys;
  } job_t;

  // One result request.
  typedef struct packed {
    logic [STICK_W-1:0] stick0;
    logic [STICK_W-1:0] stick1;
    logic [STICK_W-1:0] stick2;
    logic [STICK_W-1:0] stick3;
    logic [3:0]         switches;
    logic [WORD_W-1:0]  mouse_x;
    logic [WORD_W-1:0]  mouse_y;
    logic [WORD_W-1:0]  mouse_z;
    logic [WORD_W-1:0]  buttons;
    logic [WORD_W-1:0]  keys;
    logic [WORD_W-1:0]  feeder;
    logic               friction;
  } res_t;

endpackage

`default_nettype wire

// File: design/rcfd_front.sv
// ----------------------------------------------------------------------------
// Frame decoder front end
// Stores received bytes, unpacks complete frames and queues frame and tick
// requests for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_cmd,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_frame_end,
  output logic               job_valid,
  output rcfd_pkg::job_t     job,
  input  wire logic          job_pop
);
  import rcfd_pkg::*;

  logic [7:0]       store_r   [FRAME_BYTES];
  logic [7:0]       store_nxt [FRAME_BYTES];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;
  logic             job_push;
  logic             do_pop;
  job_t             dec;
  job_t             jq_r [2];
  logic             jq_wr_r, jq_rd_r;
  logic [1:0]       jq_cnt_r;

  assign accept   = in_push && !in_full;
  assign job_push = accept && ((in_cmd == CMD_TICK) || in_frame_end);
  assign do_pop   = job_pop && job_valid;

  // Byte storage with a saturating index that clears at frame end.
  always_comb begin
    idx_nxt = idx_r;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      store_nxt[k] = store_r[k];
    end
    if (accept && (in_cmd == CMD_BYTE)) begin
      if (idx_r < IDX_W'(FRAME_BYTES)) begin
        store_nxt[idx_r[IDX_W-1:0]] = in_data_byte;
        idx_nxt = idx_r + 1'b1;
      end
      if (in_frame_end) begin
        idx_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        store_r[k] <= '0;
      end
    end else begin
      idx_r <= idx_nxt;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        store_r[k] <= store_nxt[k];
      end
    end
  end

  // Unpack the frame, including the byte arriving this cycle.
  always_comb begin
    dec.kind    = (in_cmd == CMD_TICK) ? JOB_TICK : JOB_FRAME;
    dec.stick0  = {store_nxt[1][2:0], store_nxt[0]};
    dec.stick1  = {store_nxt[2][5:0], store_nxt[1][7:3]};
    dec.stick2  = {store_nxt[4][0], store_nxt[3], store_nxt[2][7:6]};
    dec.stick3  = {store_nxt[5][3:0], store_nxt[4][7:1]};
    dec.sw1     = store_nxt[5][7:6];
    dec.sw2     = store_nxt[5][5:4];
    dec.mouse_x = {store_nxt[7], store_nxt[6]};
    dec.mouse_y = {store_nxt[9], store_nxt[8]};
    dec.mouse_z = {store_nxt[11], store_nxt[10]};
    dec.buttons = {store_nxt[13], store_nxt[12]};
    dec.keys    = {store_nxt[15], store_nxt[14]};
  end

  // Request queue toward the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jq_wr_r  <= 1'b0;
      jq_rd_r  <= 1'b0;
      jq_cnt_r <= 2'd0;
    end else begin
      if (job_push) begin
        jq_wr_r <= ~jq_wr_r;
      end
      if (do_pop) begin
        jq_rd_r <= ~jq_rd_r;
      end
      if (job_push && !do_pop) begin
        jq_cnt_r <= jq_cnt_r + 2'd1;
      end else if (!job_push && do_pop) begin
        jq_cnt_r <= jq_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      jq_r[jq_wr_r] <= dec;
    end
  end

  assign in_full   = (jq_cnt_r == 2'd2);
  assign job_valid = (jq_cnt_r != 2'd0);
  assign job       = jq_r[jq_rd_r];

endmodule

`default_nettype wire

// File: design/rcfd_back.sv
// ----------------------------------------------------------------------------
// Frame decoder back end
// Holds the decoded controls, failsafe counter and feeder angle, and queues
// result requests in a two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rcfd_pkg::cfg_t cfg,
  input  wire logic          job_valid,
  input  wire rcfd_pkg::job_t job,
  output logic               job_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output rcfd_pkg::res_t     res
);
  import rcfd_pkg::*;

  logic [STICK_W-1:0] st0_r, st1_r, st2_r, st3_r;
  logic [STICK_W-1:0] st0_nxt, st1_nxt, st2_nxt, st3_nxt;
  logic [SW_W-1:0]    sw1_r, sw2_r, sw1_nxt, sw2_nxt;
  logic [WORD_W-1:0]  mx_r, my_r, mz_r, btn_r, key_r;
  logic [WORD_W-1:0]  mx_nxt, my_nxt, mz_nxt, btn_nxt, key_nxt;
  logic [WORD_W-1:0]  feed_r, feed_nxt;
  logic [TMO_W-1:0]   tmo_r, tmo_nxt, tmo_dec;
  logic               fric;
  logic               do_out_pop;
  res_t               res_nxt;
  res_t               oq_r [2];
  logic               oq_wr_r, oq_rd_r;
  logic [1:0]         oq_cnt_r;

  assign do_out_pop = out_pop && !out_empty;
  assign job_pop    = job_valid && ((oq_cnt_r != 2'd2) || do_out_pop);
  assign tmo_dec    = (tmo_r == '0) ? '0 : tmo_r - 1'b1;

  // Apply a frame or a tick to the held state.
  always_comb begin
    st0_nxt  = st0_r;
    st1_nxt  = st1_r;
    st2_nxt  = st2_r;
    st3_nxt  = st3_r;
    sw1_nxt  = sw1_r;
    sw2_nxt  = sw2_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    mz_nxt   = mz_r;
    btn_nxt  = btn_r;
    key_nxt  = key_r;
    feed_nxt = feed_r;
    tmo_nxt  = tmo_r;
    fric     = 1'b0;
    if (job.kind == JOB_TICK) begin
      tmo_nxt = tmo_dec;
      if (tmo_dec == '0) begin
        st0_nxt = cfg.neutral_value;
        st1_nxt = cfg.neutral_value;
        st2_nxt = cfg.neutral_value;
        st3_nxt = cfg.neutral_value;
        sw1_nxt = SW_POS_SAFE;
        sw2_nxt = SW_POS_SAFE;
      end
    end else begin
      st0_nxt = job.stick0;
      st1_nxt = job.stick1;
      st2_nxt = job.stick2;
      st3_nxt = job.stick3;
      sw1_nxt = job.sw1;
      sw2_nxt = job.sw2;
      mx_nxt  = job.mouse_x;
      my_nxt  = job.mouse_y;
      mz_nxt  = job.mouse_z;
      btn_nxt = job.buttons;
      key_nxt = job.keys;
      tmo_nxt = cfg.timeout_reload;
      fric    = (job.sw1 == SW_POS_MID);
      // Trigger edge: switch two moves from the safe to the middle position.
      if ((sw2_r == SW_POS_SAFE) && (job.sw2 == SW_POS_MID)) begin
        feed_nxt = feed_r + cfg.feeder_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_r  <= '0;
      st1_r  <= '0;
      st2_r  <= '0;
      st3_r  <= '0;
      sw1_r  <= '0;
      sw2_r  <= '0;
      mx_r   <= '0;
      my_r   <= '0;
      mz_r   <= '0;
      btn_r  <= '0;
      key_r  <= '0;
      feed_r <= '0;
      tmo_r  <= '0;
    end else if (job_pop) begin
      st0_r  <= st0_nxt;
      st1_r  <= st1_nxt;
      st2_r  <= st2_nxt;
      st3_r  <= st3_nxt;
      sw1_r  <= sw1_nxt;
      sw2_r  <= sw2_nxt;
      mx_r   <= mx_nxt;
      my_r   <= my_nxt;
      mz_r   <= mz_nxt;
      btn_r  <= btn_nxt;
      key_r  <= key_nxt;
      feed_r <= feed_nxt;
      tmo_r  <= tmo_nxt;
    end
  end

  // Assemble the result from the updated state.
  always_comb begin
    res_nxt.stick0   = st0_nxt;
    res_nxt.stick1   = st1_nxt;
    res_nxt.stick2   = st2_nxt;
    res_nxt.stick3   = st3_nxt;
    res_nxt.switches = {sw1_nxt, sw2_nxt};
    res_nxt.mouse_x  = mx_nxt;
    res_nxt.mouse_y  = my_nxt;
    res_nxt.mouse_z  = mz_nxt;
    res_nxt.buttons  = btn_nxt;
    res_nxt.keys     = key_nxt;
    res_nxt.feeder   = feed_nxt;
    res_nxt.friction = fric;
  end

  // Output queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (job_pop) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (do_out_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      if (job_pop && !do_out_pop) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (!job_pop && do_out_pop) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      oq_r[oq_wr_r] <= res_nxt;
    end
  end

  assign out_empty = (oq_cnt_r == 2'd0);
  assign res       = oq_r[oq_rd_r];

endmodule

`default_nettype wire

// File: design/rc_frame_decoder_failsafe.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder with failsafe
// Decodes receiver frames into stick, switch, mouse and key fields, and forces
// neutral controls when timer ticks arrive without frames.
//
//   Port group  Direction  Handshake       Contents
//   in_*        input      push / full     cmd, data_byte, frame_end
//   out_*       output     empty / pop     decoded controls, feeder angle
//   cfg_*       input      cfg_we          timeout, neutral value, feeder step
//
// One request is accepted every cycle while in_full is low; a frame end or
// tick reaches the result ports through the front queue and then the output
// queue, and waits in the front queue while the output queue is full.
// Both queues hold two requests, so full rises only after the output side
// has stalled long enough to fill them. Reset is synchronous; there is no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_frame_decoder_failsafe (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic                           in_cmd,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_frame_end,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [rcfd_pkg::STICK_W-1:0]        out_stick0,
  output logic [rcfd_pkg::STICK_W-1:0]        out_stick1,
  output logic [rcfd_pkg::STICK_W-1:0]        out_stick2,
  output logic [rcfd_pkg::STICK_W-1:0]        out_stick3,
  output logic [3:0]                          out_switches,
  output logic signed [rcfd_pkg::WORD_W-1:0]  out_mouse_x,
  output logic signed [rcfd_pkg::WORD_W-1:0]  out_mouse_y,
  output logic signed [rcfd_pkg::WORD_W-1:0]  out_mouse_z,
  output logic [rcfd_pkg::WORD_W-1:0]         out_mouse_buttons,
  output logic [rcfd_pkg::WORD_W-1:0]         out_key_bits,
  output logic [rcfd_pkg::WORD_W-1:0]         out_feeder_angle,
  output logic                                out_friction_start,
  input  wire logic                           cfg_we,
  input  wire logic [rcfd_pkg::CFGI_W-1:0]    cfg_index,
  input  wire logic [rcfd_pkg::CFG_W-1:0]     cfg_data
);
  import rcfd_pkg::*;

  cfg_t cfg_r;
  logic job_valid;
  logic job_pop;
  job_t job;
  res_t res;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_reload <= RST_TIMEOUT_RELOAD;
      cfg_r.neutral_value  <= RST_NEUTRAL_VALUE;
      cfg_r.feeder_step    <= RST_FEEDER_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_RELOAD: cfg_r.timeout_reload <= cfg_data[TMO_W-1:0];
        CFG_NEUTRAL_VALUE:  cfg_r.neutral_value  <= cfg_data[STICK_W-1:0];
        CFG_FEEDER_STEP:    cfg_r.feeder_step    <= cfg_data[WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte capture and frame unpacking.
  rcfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop)
  );

  // State update, failsafe and result queue.
  rcfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  // Result fields.
  assign out_stick0         = res.stick0;
  assign out_stick1         = res.stick1;
  assign out_stick2         = res.stick2;
  assign out_stick3         = res.stick3;
  assign out_switches       = res.switches;
  assign out_mouse_x        = res.mouse_x;
  assign out_mouse_y        = res.mouse_y;
  assign out_mouse_z        = res.mouse_z;
  assign out_mouse_buttons  = res.buttons;
  assign out_key_bits       = res.keys;
  assign out_feeder_angle   = res.feeder;
  assign out_friction_start = res.friction;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder testbench
// Drives receiver bytes and timer ticks into the decoder through its queue
// interface and keeps a cycle-free model of the decoded controls. Every result
// request is checked field by field against the oldest predicted one. The run
// covers full, short and overrun frames, failsafe, feeder triggers, several
// register settings, random idling on both sides and long output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rcfd_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 6;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_FRAME      = 32;
  localparam int ITEMS_PER_PASS = 200;
  localparam logic [CFGI_W-1:0] CFG_SPARE_INDEX = 2'd3;

  // Receiver behavior when it is not held off.
  typedef enum int {
    RX_FREE,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_t;

  // Ports of the block.
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic                      in_cmd = CMD_BYTE;
  logic [7:0]                in_data_byte = 8'd0;
  logic                      in_frame_end = 1'b0;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic [STICK_W-1:0]        out_stick0;
  logic [STICK_W-1:0]        out_stick1;
  logic [STICK_W-1:0]        out_stick2;
  logic [STICK_W-1:0]        out_stick3;
  logic [3:0]                out_switches;
  logic signed [WORD_W-1:0]  out_mouse_x;
  logic signed [WORD_W-1:0]  out_mouse_y;
  logic signed [WORD_W-1:0]  out_mouse_z;
  logic [WORD_W-1:0]         out_mouse_buttons;
  logic [WORD_W-1:0]         out_key_bits;
  logic [WORD_W-1:0]         out_feeder_angle;
  logic                      out_friction_start;
  logic                      cfg_we = 1'b0;
  logic [CFGI_W-1:0]         cfg_index = CFG_TIMEOUT_RELOAD;
  logic [CFG_W-1:0]          cfg_data = '0;

  // Decoder model state and its copy of the registers.
  logic [7:0]          rx_store [FRAME_BYTES];
  int                  store_index = 0;
  logic [STICK_W-1:0]  sticks [4];
  logic [SW_W-1:0]     sw_one = '0;
  logic [SW_W-1:0]     sw_two = '0;
  logic [WORD_W-1:0]   mouse_words [3];
  logic [WORD_W-1:0]   button_word = '0;
  logic [WORD_W-1:0]   key_word = '0;
  logic [WORD_W-1:0]   feeder_acc = '0;
  logic [TMO_W-1:0]    failsafe_count = '0;
  logic [TMO_W-1:0]    timeout_reload_r = RST_TIMEOUT_RELOAD;
  logic [STICK_W-1:0]  neutral_r = RST_NEUTRAL_VALUE;
  logic [WORD_W-1:0]   feeder_step_r = RST_FEEDER_STEP;

  // Decoded controls still owed by the block, oldest first.
  res_t pending_controls [$];

  // Sender and receiver controls.
  logic [7:0]  frame_buf [MAX_FRAME];
  int          burst_left = 0;
  bit          sender_bursty = 1'b1;
  rx_mode_t    rx_mode = RX_FREE;
  int          hold_len = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  logic [7:0]  stall_pattern = 8'b1011_0110;
  int          pattern_age = 0;

  // Run statistics.
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int failsafe_ticks = 0;
  int trigger_count = 0;
  int dropped_bytes = 0;
  int cycle_count = 0;

  rc_frame_decoder_failsafe dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_data_byte       (in_data_byte),
    .in_frame_end       (in_frame_end),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_stick0         (out_stick0),
    .out_stick1         (out_stick1),
    .out_stick2         (out_stick2),
    .out_stick3         (out_stick3),
    .out_switches       (out_switches),
    .out_mouse_x        (out_mouse_x),
    .out_mouse_y        (out_mouse_y),
    .out_mouse_z        (out_mouse_z),
    .out_mouse_buttons  (out_mouse_buttons),
    .out_key_bits       (out_key_bits),
    .out_feeder_angle   (out_feeder_angle),
    .out_friction_start (out_friction_start),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    foreach (rx_store[i]) rx_store[i] = 8'd0;
    foreach (sticks[i]) sticks[i] = '0;
    foreach (mouse_words[i]) mouse_words[i] = '0;
    foreach (frame_buf[i]) frame_buf[i] = 8'd0;
  end

  // Updates the decoder model with one accepted request and queues the
  // controls it should produce.
  task automatic predict_controls(input logic cmd, input logic [7:0] data,
                                  input logic fend);
    res_t ctl;
    logic emits;
    logic friction;
    logic [SW_W-1:0] sw_two_last;
    emits = 1'b0;
    friction = 1'b0;
    if (cmd == CMD_TICK) begin
      // A tick counts the failsafe timer down and goes neutral at zero.
      if (failsafe_count != 0) failsafe_count--;
      if (failsafe_count == 0) begin
        foreach (sticks[i]) sticks[i] = neutral_r;
        sw_one = SW_POS_SAFE;
        sw_two = SW_POS_SAFE;
        failsafe_ticks++;
      end
      emits = 1'b1;
    end else begin
      if (store_index < FRAME_BYTES) begin
        rx_store[store_index] = data;
        store_index++;
      end else begin
        dropped_bytes++;
      end
      if (fend) begin
        // Unpack the first sixteen bytes of the store.
        store_index = 0;
        sticks[0] = {rx_store[1][2:0], rx_store[0]};
        sticks[1] = {rx_store[2][5:0], rx_store[1][7:3]};
        sticks[2] = {rx_store[4][0], rx_store[3], rx_store[2][7:6]};
        sticks[3] = {rx_store[5][3:0], rx_store[4][7:1]};
        sw_two_last = sw_two;
        sw_one = rx_store[5][7:6];
        sw_two = rx_store[5][5:4];
        mouse_words[0] = {rx_store[7], rx_store[6]};
        mouse_words[1] = {rx_store[9], rx_store[8]};
        mouse_words[2] = {rx_store[11], rx_store[10]};
        button_word = {rx_store[13], rx_store[12]};
        key_word = {rx_store[15], rx_store[14]};
        failsafe_count = timeout_reload_r;
        if (sw_two_last == SW_POS_SAFE && sw_two == SW_POS_MID) begin
          feeder_acc = feeder_acc + feeder_step_r;
          trigger_count++;
        end
        friction = (sw_one == SW_POS_MID);
        emits = 1'b1;
      end
    end
    if (emits) begin
      ctl.stick0 = sticks[0];
      ctl.stick1 = sticks[1];
      ctl.stick2 = sticks[2];
      ctl.stick3 = sticks[3];
      ctl.switches = {sw_one, sw_two};
      ctl.mouse_x = mouse_words[0];
      ctl.mouse_y = mouse_words[1];
      ctl.mouse_z = mouse_words[2];
      ctl.buttons = button_word;
      ctl.keys = key_word;
      ctl.feeder = feeder_acc;
      ctl.friction = friction;
      pending_controls.push_back(ctl);
    end
  endtask

  // Offers one request and waits until the block takes it. The sender works
  // in bursts; push stays high across a burst.
  task automatic send_item(input logic cmd, input logic [7:0] data, input logic fend);
    if (burst_left == 0) begin
      if (sender_bursty) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_data_byte <= data;
    in_frame_end <= fend;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    predict_controls(cmd, data, fend);
    items_sent++;
    burst_left--;
  endtask

  // Sends the first nbytes of the frame buffer, marking the last as frame end.
  task automatic send_frame(input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_item(CMD_BYTE, frame_buf[i], i == nbytes - 1);
    end
  endtask

  // Lays out the stick and switch fields in the frame buffer as the receiver
  // sends them. Bytes from byte six on are filled with random values.
  task automatic pack_controls(input logic [STICK_W-1:0] s0, input logic [STICK_W-1:0] s1,
                               input logic [STICK_W-1:0] s2, input logic [STICK_W-1:0] s3,
                               input logic [SW_W-1:0] sw1, input logic [SW_W-1:0] sw2);
    frame_buf[0] = s0[7:0];
    frame_buf[1] = {s1[4:0], s0[10:8]};
    frame_buf[2] = {s2[1:0], s1[10:5]};
    frame_buf[3] = s2[9:2];
    frame_buf[4] = {s3[6:0], s2[10]};
    frame_buf[5] = {sw1, sw2, s3[10:7]};
    for (int i = 6; i < MAX_FRAME; i++) frame_buf[i] = 8'($urandom_range(0, 255));
  endtask

  function automatic logic [SW_W-1:0] SW_POS_SW_ANY();
    return SW_W'($urandom_range(0, 3));
  endfunction

  // Switch positions lean toward mid and safe so triggers and friction occur.
  function automatic logic [SW_W-1:0] pick_switch();
    if ($urandom_range(0, 3) == 0) return SW_POS_SW_ANY();
    return $urandom_range(0, 1) ? SW_POS_MID : SW_POS_SAFE;
  endfunction

  task automatic send_random_frame(input int nbytes);
    pack_controls(STICK_W'($urandom_range(0, 2047)), STICK_W'($urandom_range(0, 2047)),
                  STICK_W'($urandom_range(0, 2047)), STICK_W'($urandom_range(0, 2047)),
                  pick_switch(), pick_switch());
    send_frame(nbytes);
  endtask

  // Stops sending and waits until every predicted request has come out,
  // then lets any frame bytes still inside settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    burst_left = 0;
    while (pending_controls.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register and mirrors it into the model.
  task automatic write_reg(input logic [CFGI_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    case (index)
      CFG_TIMEOUT_RELOAD: timeout_reload_r = data[TMO_W-1:0];
      CFG_NEUTRAL_VALUE:  neutral_r = data[STICK_W-1:0];
      CFG_FEEDER_STEP:    feeder_step_r = data[WORD_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed frames and tick runs, with some noise mixed in.
  task automatic random_traffic(input int count);
    int stop_at;
    int pick;
    int nbytes;
    int ticks;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        nbytes = $urandom_range(0, 9);
        if (nbytes == 0) nbytes = $urandom_range(1, FRAME_BYTES - 3);
        else if (nbytes == 1) nbytes = $urandom_range(FRAME_BYTES + 1, MAX_FRAME);
        else nbytes = $urandom_range(16, FRAME_BYTES);
        send_random_frame(nbytes);
      end else if (pick <= 7) begin
        if ($urandom_range(0, 7) == 0) ticks = int'(timeout_reload_r) + 1;
        else ticks = $urandom_range(1, 6);
        repeat (ticks) send_item(CMD_TICK, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  // First tick after reset, an all-ones frame and a short zero frame that
  // sets both switches to mid.
  task automatic test_reset_and_extremes();
    send_item(CMD_TICK, 8'h00, 1'b0);
    foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
    send_frame(FRAME_BYTES);
    for (int i = 0; i < 6; i++) frame_buf[i] = 8'h00;
    frame_buf[5] = {SW_POS_MID, SW_POS_MID, 4'h0};
    send_frame(6);
  endtask

  // Ticks run the timer out; the next mid frame counts as a trigger because
  // failsafe left switch two at safe.
  task automatic test_failsafe();
    pack_controls(STICK_W'($urandom_range(0, 2047)), STICK_W'($urandom_range(0, 2047)),
                  STICK_W'($urandom_range(0, 2047)), STICK_W'($urandom_range(0, 2047)),
                  SW_POS_SAFE, SW_POS_MID);
    send_frame(FRAME_BYTES);
    repeat (int'(timeout_reload_r) + 2) send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
    pack_controls(STICK_W'($urandom_range(0, 2047)), STICK_W'($urandom_range(0, 2047)),
                  STICK_W'($urandom_range(0, 2047)), STICK_W'($urandom_range(0, 2047)),
                  SW_POS_MID, SW_POS_MID);
    send_frame(FRAME_BYTES);
    send_item(CMD_TICK, 8'h00, 1'b0);
  endtask

  // Frames longer than the store drop their tail; a short frame follows.
  task automatic test_overrun();
    send_random_frame(FRAME_BYTES + 1);
    send_random_frame(MAX_FRAME);
    send_random_frame($urandom_range(FRAME_BYTES + 2, MAX_FRAME - 1));
    send_random_frame(3);
  endtask

  // The receiver holds off for a long stretch while ticks and one-byte
  // frames keep coming, so the queues fill and the input stalls.
  task automatic test_output_holdoff();
    wait_idle();
    sender_bursty = 1'b0;
    hold_len = 300;
    hold_req++;
    repeat (40) begin
      if ($urandom_range(0, 1)) send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
      else send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b1);
    end
    wait_idle();
    sender_bursty = 1'b1;
  endtask

  // One pass of random traffic under a register setting.
  task automatic run_setting(input logic [CFG_W-1:0] reload_word,
                             input logic [CFG_W-1:0] neutral_word,
                             input logic [CFG_W-1:0] step_word,
                             input rx_mode_t mode, input bit bursty);
    wait_idle();
    write_reg(CFG_TIMEOUT_RELOAD, reload_word);
    write_reg(CFG_NEUTRAL_VALUE, neutral_word);
    write_reg(CFG_FEEDER_STEP, step_word);
    rx_mode = mode;
    sender_bursty = bursty;
    random_traffic(ITEMS_PER_PASS);
  endtask

  // Register extremes, masking of wide writes and an unused index.
  task automatic test_register_settings();
    run_setting(16'hA501, 16'h0000, 16'hFFFF, RX_RANDOM, 1'b1);
    run_setting(16'h00FF, 16'h07FF, 16'h0000, RX_PATTERN, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE_INDEX, 16'hFFFF);
    run_setting(16'hFF00, 16'hFAAA, 16'h1234, RX_FREE, 1'b1);
    run_setting(16'h5A05, CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                RX_PATTERN, 1'b1);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Checks each popped result request and decides the next pop.
  always @(posedge clk) begin
    res_t want;
    if (out_pop === 1'b1 && out_empty === 1'b0) begin
      if (pending_controls.size() == 0) begin
        $error("result request with no prediction waiting");
        error_count++;
      end else begin
        want = pending_controls.pop_front();
        check_field("stick0", WORD_W'(want.stick0), WORD_W'(out_stick0));
        check_field("stick1", WORD_W'(want.stick1), WORD_W'(out_stick1));
        check_field("stick2", WORD_W'(want.stick2), WORD_W'(out_stick2));
        check_field("stick3", WORD_W'(want.stick3), WORD_W'(out_stick3));
        check_field("switches", WORD_W'(want.switches), WORD_W'(out_switches));
        check_field("mouse_x", want.mouse_x, out_mouse_x);
        check_field("mouse_y", want.mouse_y, out_mouse_y);
        check_field("mouse_z", want.mouse_z, out_mouse_z);
        check_field("mouse_buttons", want.buttons, out_mouse_buttons);
        check_field("key_bits", want.keys, out_key_bits);
        check_field("feeder_angle", want.feeder, out_feeder_angle);
        check_field("friction_start", WORD_W'(want.friction), WORD_W'(out_friction_start));
        results_checked++;
      end
    end
    if (hold_req != hold_ack) begin
      hold_left = hold_len;
      hold_ack = hold_req;
    end
    // The stall pattern rotates every cycle and is redrawn now and then.
    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
    pattern_age++;
    if (pattern_age == 32) begin
      pattern_age = 0;
      stall_pattern = 8'($urandom_range(0, 255));
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:    out_pop <= 1'b1;
        RX_PATTERN: out_pop <= stall_pattern[0];
        default:    out_pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Ends a run that hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_mode = RX_PATTERN;
    test_reset_and_extremes();
    test_failsafe();
    test_overrun();
    test_output_holdoff();
    random_traffic(ITEMS_PER_PASS);
    test_register_settings();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_controls.size() != 0) begin
      $error("%0d predicted result requests never came out", pending_controls.size());
      error_count++;
    end
    $display("Sent %0d input requests and checked %0d results in %0d cycles.",
             items_sent, results_checked, cycle_count);
    $display("Saw %0d failsafe ticks, %0d feeder triggers and %0d dropped overrun bytes.",
             failsafe_ticks, trigger_count, dropped_bytes);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/rcfd_pkg.sv
design/rcfd_front.sv
design/rcfd_back.sv
design/rc_frame_decoder_failsafe.sv
tb/sv/testbench.sv
